### hdl/slcd_pkg.sv
// Shared types and constants for the sync, length and checksum deframer.
package slcd_pkg;

    localparam int DEFAULT_BUFFER_DEPTH = 256;

    localparam int BYTE_W = 8;
    localparam int KIND_W = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    localparam logic [0:0] REG_MAX_FRAME_LENGTH = 1'b0;
    localparam logic [BYTE_W-1:0] MAX_FRAME_LENGTH_RESET = 8'hFF;

    typedef struct packed {
        logic              wr_en;
        logic [BYTE_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic              frame_ready;
        logic [BYTE_W-1:0] payload_length;
    } slcd_status_t;

endpackage

### hdl/slcd_parser.sv
// Frame parser: header, length, payload count and checksum state machine.
module slcd_parser
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic [slcd_pkg::KIND_W-1:0]   kind,
    input  logic [slcd_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [slcd_pkg::BYTE_W-1:0]   max_frame_length,
    output slcd_pkg::slcd_status_t        status
);

    localparam logic [2:0] PH_WAIT_H1 = 3'd0;
    localparam logic [2:0] PH_WAIT_H2 = 3'd1;
    localparam logic [2:0] PH_LENGTH = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK = 3'd4;
    localparam logic [2:0] PH_HOLD = 3'd5;

    localparam logic [slcd_pkg::BYTE_W-1:0] SYNC_BYTE = 8'hFF;
    localparam logic [slcd_pkg::BYTE_W-1:0] ZERO_BYTE = 8'h00;
    // Wrapped sum of the two sync bytes.
    localparam logic [slcd_pkg::BYTE_W-1:0] SYNC_SUM = 8'hFE;

    logic [2:0]                    phase_reg;
    logic [2:0]                    phase_next;
    logic [slcd_pkg::BYTE_W-1:0]   expected_reg;
    logic [slcd_pkg::BYTE_W-1:0]   expected_next;
    logic [slcd_pkg::BYTE_W-1:0]   received_reg;
    logic [slcd_pkg::BYTE_W-1:0]   received_next;
    logic [slcd_pkg::BYTE_W-1:0]   sum_reg;
    logic [slcd_pkg::BYTE_W-1:0]   sum_next;
    logic [slcd_pkg::BYTE_W-1:0]   received_inc;
    logic                          byte_in;

    assign byte_in = take && (kind == slcd_pkg::KIND_BYTE);
    assign received_inc = received_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        expected_next = expected_reg;
        received_next = received_reg;
        sum_next = sum_reg;
        if (take)
        begin
            case (kind)
                slcd_pkg::KIND_BYTE:
                begin
                    case (phase_reg)
                        PH_WAIT_H1:
                        begin
                            if (rx_byte == SYNC_BYTE)
                            begin
                                phase_next = PH_WAIT_H2;
                            end
                        end
                        PH_WAIT_H2:
                        begin
                            phase_next = (rx_byte == SYNC_BYTE) ? PH_LENGTH : PH_WAIT_H1;
                        end
                        PH_LENGTH:
                        begin
                            if ((rx_byte == ZERO_BYTE) || (rx_byte > max_frame_length))
                            begin
                                phase_next = PH_WAIT_H1;
                            end
                            else
                            begin
                                expected_next = rx_byte - 8'd1;
                                received_next = ZERO_BYTE;
                                sum_next = SYNC_SUM + rx_byte;
                                phase_next = (rx_byte == 8'd1) ? PH_CHECK : PH_PAYLOAD;
                            end
                        end
                        PH_PAYLOAD:
                        begin
                            received_next = received_inc;
                            sum_next = sum_reg + rx_byte;
                            if (received_inc == expected_reg)
                            begin
                                phase_next = PH_CHECK;
                            end
                        end
                        PH_CHECK:
                        begin
                            phase_next = (sum_reg == rx_byte) ? PH_HOLD : PH_WAIT_H1;
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                slcd_pkg::KIND_RELEASE:
                begin
                    phase_next = PH_WAIT_H1;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT_H1;
            expected_reg <= '0;
            received_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            expected_reg <= expected_next;
            received_reg <= received_next;
            sum_reg <= sum_next;
        end
    end

    assign status.wr_en = byte_in && (phase_reg == PH_PAYLOAD);
    assign status.wr_addr = received_reg;
    assign status.wr_data = rx_byte;
    assign status.frame_ready = (phase_next == PH_HOLD);
    assign status.payload_length = (phase_next == PH_HOLD) ? expected_next : ZERO_BYTE;

endmodule

### hdl/sync_length_checksum_deframer.sv
// Top level of the sync, length and checksum deframer with payload store.
//
// Items arrive on the s_ stream: s_tuser carries the kind (received byte,
// release of a held frame, or payload read) and s_tdata the byte and the
// read index. Every transfer in gives exactly one transfer out on the m_
// stream, carrying the held-frame flag, the payload length and read data.
// The frame state is updated in the cycle of the input transfer; the result
// reaches m_tvalid through a result register that also holds the registered
// payload store read, and then through an output register.
// One item is taken per cycle while the receiver keeps m_tready high.
// When the receiver stalls, the result register still takes one further
// item before s_tready drops; nothing is lost or repeated.
// The APB port sets the largest accepted length byte; the user must write it
// only while the block is idle, which the block itself does not enforce.
// Reset clears the frame state and both output stages and sets the maximum
// length to 255; the payload store is not cleared, and reading a position
// that was never written gives no defined value.
module sync_length_checksum_deframer
#(
    parameter int BUFFER_DEPTH = slcd_pkg::DEFAULT_BUFFER_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [slcd_pkg::IN_DATA_W-1:0]    s_tdata,   // rx_byte, read_index
    input  logic [slcd_pkg::KIND_W-1:0]       s_tuser,   // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [slcd_pkg::OUT_DATA_W-1:0]   m_tdata,   // frame_ready, payload_length, read_data
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [slcd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [slcd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [slcd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [slcd_pkg::BYTE_W:0] DEPTH_LIMIT = (slcd_pkg::BYTE_W + 1)'(BUFFER_DEPTH);

    logic [slcd_pkg::BYTE_W-1:0]   max_len_reg;
    logic                          cfg_write;

    logic                          accept;
    logic                          advance;
    logic                          s1_move;
    logic [slcd_pkg::KIND_W-1:0]   kind;
    logic [slcd_pkg::BYTE_W-1:0]   rx_byte;
    logic [slcd_pkg::BYTE_W-1:0]   read_index;
    slcd_pkg::slcd_status_t        status;

    logic [slcd_pkg::BYTE_W-1:0]   store [BUFFER_DEPTH];
    logic                          wr_in_range;
    logic                          rd_valid;

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic                          s1_ready_reg;
    logic [slcd_pkg::BYTE_W-1:0]   s1_len_reg;
    logic                          s1_rd_ok_reg;
    logic [slcd_pkg::BYTE_W-1:0]   rd_data_reg;
    logic [slcd_pkg::BYTE_W-1:0]   read_data;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [slcd_pkg::OUT_DATA_W-1:0] m_data_reg;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == slcd_pkg::REG_MAX_FRAME_LENGTH);
    assign prdata = (paddr[2] == slcd_pkg::REG_MAX_FRAME_LENGTH)
                    ? {{(slcd_pkg::APB_DATA_W - slcd_pkg::BYTE_W){1'b0}}, max_len_reg}
                    : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= slcd_pkg::MAX_FRAME_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            max_len_reg <= pwdata[slcd_pkg::BYTE_W-1:0];
        end
    end

    assign kind = s_tuser;
    assign rx_byte = s_tdata[slcd_pkg::BYTE_W-1:0];
    assign read_index = s_tdata[2*slcd_pkg::BYTE_W-1:slcd_pkg::BYTE_W];

    assign advance = !m_valid_reg || m_tready;
    assign s1_move = s1_valid_reg && advance;
    assign s_tready = !s1_valid_reg || advance;
    assign accept = s_tvalid && s_tready;

    slcd_parser u_parser
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (accept),
        .kind             (kind),
        .rx_byte          (rx_byte),
        .max_frame_length (max_len_reg),
        .status           (status)
    );

    assign wr_in_range = ({1'b0, status.wr_addr} < DEPTH_LIMIT);
    assign rd_valid = (kind == slcd_pkg::KIND_READ) && ({1'b0, read_index} < DEPTH_LIMIT);

    always_ff @(posedge clk)
    begin
        if (status.wr_en && wr_in_range)
        begin
            store[status.wr_addr[AW-1:0]] <= status.wr_data;
        end
        if (accept && rd_valid)
        begin
            rd_data_reg <= store[read_index[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ready_reg <= status.frame_ready;
            s1_len_reg <= status.payload_length;
            s1_rd_ok_reg <= rd_valid;
        end
        if (s1_move)
        begin
            m_data_reg <= {{(slcd_pkg::OUT_DATA_W - 2*slcd_pkg::BYTE_W - 1){1'b0}},
                           read_data, s1_len_reg, s1_ready_reg};
        end
    end

    assign read_data = s1_rd_ok_reg ? rd_data_reg : '0;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (s1_move)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;

endmodule
